### rtl/lsbs_pkg.sv
package lsbs_pkg;

	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_GATE_LOW = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GATE_HIGH = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BREAK_GAP = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPAN_COS = 8'd3;

	localparam logic signed [15:0] RST_GATE_LOW = -16'sd10000;
	localparam logic signed [15:0] RST_GATE_HIGH = 16'sd10000;
	localparam logic [15:0] RST_BREAK_GAP = 16'd300;
	localparam logic signed [15:0] RST_SPAN_COS = 16'sd32270;

	// Q1.15 scale squared
	localparam int COS_SHIFT = 30;
	localparam int COS_SQ_W = 31;

endpackage

### rtl/lsbs_mul.sv
module lsbs_mul #(
	parameter int AW = 95,
	parameter int BW = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [AW-1:0] mcand,
	input  logic [BW-1:0] mplier,
	output logic          done,
	output logic [AW-1:0] product
);

	logic          busy_q;
	logic [AW-1:0] mc_q;
	logic [BW-1:0] mp_q;
	logic [AW-1:0] acc_q;

	// shift-add, one multiplier bit a cycle, stops early once the multiplier runs out
	assign done = busy_q && (mp_q == '0);
	assign product = acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
		end else if (done) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mc_q <= mcand;
			mp_q <= mplier;
			acc_q <= '0;
		end else if (busy_q && !done) begin
			if (mp_q[0]) begin
				acc_q <= acc_q + mc_q;
			end
			mc_q <= mc_q << 1;
			mp_q <= mp_q >> 1;
		end
	end

endmodule

### rtl/lidar_scan_breakpoint_segmenter.sv
// A gated point goes straight to the end check; one that opens or extends a cluster first takes
// the distance, gap and length squares and the decision. A closed cluster adds the span test:
// dot product and cosine square, then, unless the signs settle it, three bit-serial products
// (|first|^2*|last|^2, times cos^2, and dot^2) plus compare and result, twice when a break ends
// a scan. A stalled result register holds the block where it is. One point is in flight at a time.
// Reset: registers take their reset values, no cluster is open, the output register is empty.
module lidar_scan_breakpoint_segmenter #(
	parameter int COORD_BITS = 16,
	localparam int S_TDATA_W = ((2*COORD_BITS + 7) / 8) * 8,
	localparam int M_TDATA_W = ((6*COORD_BITS + 7) / 8) * 8
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [lsbs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [lsbs_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [S_TDATA_W-1:0]           s_tdata,  // pt_x, pt_y
	input  logic                           s_tlast,  // scan_end
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [M_TDATA_W-1:0]           m_tdata,  // start_x, start_y, end_x, end_y, near_x, near_y
	output logic                           m_tuser,  // seg_valid
	output logic                           m_tlast   // scan_done
);

	import lsbs_pkg::*;

	localparam int CB = COORD_BITS;
	localparam int MW = (CB + 1 > 17) ? CB + 1 : 17;
	localparam int GW = ((CB > 16) ? CB : 16) + 1;
	localparam int DW = 2*CB + 2;
	localparam int LW = 2*CB;
	localparam int DTW = 2*CB + 1;
	localparam int MPW = (LW > COS_SQ_W) ? LW : COS_SQ_W;
	localparam int PW = 2*LW + COS_SQ_W;
	localparam int CW = (DW > 32) ? DW : 32;

	typedef enum logic [4:0] {
		S_IDLE, S_PDX, S_PDY, S_PGAP, S_PX, S_PY, S_DECIDE, S_ENDCHK,
		S_DOT1, S_DOT2, S_CSQ, S_TEST, S_M1, S_M1W, S_M2, S_M2W, S_M3, S_M3W,
		S_CMP, S_RESULT
	} state_t;

	state_t state_q;

	logic signed [15:0] gate_lo_q, gate_hi_q, cos_q;
	logic [15:0]        gap_q;

	logic signed [CB-1:0] x_q, y_q;
	logic                 end_q;
	logic                 open_q, brk_q, ok_q;
	logic signed [CB-1:0] hx_q, hy_q, tx_q, ty_q, nx_q, ny_q;
	logic [LW-1:0]        head_len_q, tail_len_q, near_len_q, len_q;
	logic [DW-1:0]        dist_q;
	logic [31:0]          gap2_q;
	logic signed [DTW-1:0] dot_q;
	logic [COS_SQ_W-1:0]  c2_q;
	logic [PW-1:0]        r_q;

	logic                 m_tvalid_q, seg_q, done_q;
	logic signed [CB-1:0] osx_q, osy_q, oex_q, oey_q, onx_q, ony_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gate_lo_q <= RST_GATE_LOW;
			gate_hi_q <= RST_GATE_HIGH;
			gap_q <= RST_BREAK_GAP;
			cos_q <= RST_SPAN_COS;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_GATE_LOW: gate_lo_q <= signed'(cfg_data);
				REG_GATE_HIGH: gate_hi_q <= signed'(cfg_data);
				REG_BREAK_GAP: gap_q <= cfg_data;
				REG_SPAN_COS: cos_q <= signed'(cfg_data);
				default: ;
			endcase
		end
	end

	// gate on the incoming beat
	logic signed [CB-1:0] in_x, in_y;
	logic signed [GW-1:0] gx, gy, glo, ghi;
	logic                 in_kept;
	assign in_x = signed'(s_tdata[CB-1:0]);
	assign in_y = signed'(s_tdata[2*CB-1:CB]);
	assign gx = GW'(in_x);
	assign gy = GW'(in_y);
	assign glo = GW'(gate_lo_q);
	assign ghi = GW'(gate_hi_q);
	assign in_kept = (gx > glo) && (gx < ghi) && (gy > glo) && (gy < ghi);

	// shared single-cycle multiplier for the narrow products
	logic signed [MW-1:0]   ma;
	logic signed [2*MW-1:0] prod;
	logic signed [CB:0]     dx, dy;
	logic signed [16:0]     c17, cm;
	assign dx = (CB+1)'(x_q) - (CB+1)'(tx_q);
	assign dy = (CB+1)'(y_q) - (CB+1)'(ty_q);
	assign c17 = 17'(cos_q);
	assign cm = cos_q[15] ? -c17 : c17;

	logic signed [MW-1:0] mb;
	always_comb begin
		ma = '0;
		mb = '0;
		case (state_q)
			S_PDX: begin ma = MW'(dx); mb = MW'(dx); end
			S_PDY: begin ma = MW'(dy); mb = MW'(dy); end
			S_PGAP: begin
				ma = MW'(signed'({1'b0, gap_q}));
				mb = MW'(signed'({1'b0, gap_q}));
			end
			S_PX: begin ma = MW'(x_q); mb = MW'(x_q); end
			S_PY: begin ma = MW'(y_q); mb = MW'(y_q); end
			S_DOT1: begin ma = MW'(hx_q); mb = MW'(tx_q); end
			S_DOT2: begin ma = MW'(hy_q); mb = MW'(ty_q); end
			S_CSQ: begin ma = MW'(cm); mb = MW'(cm); end
			default: ;
		endcase
	end
	assign prod = ma * mb;

	logic [DTW-1:0] dot_abs;
	logic           dot_le0, dot_ge0, c_neg;
	assign dot_abs = dot_q[DTW-1] ? unsigned'(-dot_q) : unsigned'(dot_q);
	assign dot_le0 = dot_q[DTW-1] || (dot_q == '0);
	assign dot_ge0 = !dot_q[DTW-1];
	assign c_neg = cos_q[15];

	// wide products for the span test
	logic           ser_start, ser_done;
	logic [PW-1:0]  ser_mcand, ser_prod, lhs;
	logic [MPW-1:0] ser_mplier;
	always_comb begin
		ser_start = 1'b0;
		ser_mcand = '0;
		ser_mplier = '0;
		case (state_q)
			S_M1: begin
				ser_start = 1'b1;
				ser_mcand = PW'(head_len_q);
				ser_mplier = MPW'(tail_len_q);
			end
			S_M2: begin
				ser_start = 1'b1;
				ser_mcand = ser_prod;
				ser_mplier = MPW'(c2_q);
			end
			S_M3: begin
				ser_start = 1'b1;
				ser_mcand = PW'(dot_abs[LW-1:0]);
				ser_mplier = MPW'(dot_abs[LW-1:0]);
			end
			default: ;
		endcase
	end
	assign lhs = ser_prod << COS_SHIFT;

	lsbs_mul #(.AW(PW), .BW(MPW)) u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (ser_start),
		.mcand   (ser_mcand),
		.mplier  (ser_mplier),
		.done    (ser_done),
		.product (ser_prod)
	);

	logic out_free;
	logic out_load;
	logic extend;
	assign out_free = !m_tvalid_q || m_tready;
	// a result beat is loaded on an empty-scan flush or from the span test
	assign out_load = out_free && (((state_q == S_ENDCHK) && end_q && !open_q)
		|| ((state_q == S_RESULT) && (ok_q || !brk_q)));
	assign extend = CW'(dist_q) <= CW'(gap2_q);
	assign s_tready = (state_q == S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			open_q <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						x_q <= in_x;
						y_q <= in_y;
						end_q <= s_tlast;
						state_q <= in_kept ? S_PDX : S_ENDCHK;
					end
				end
				S_PDX: begin
					dist_q <= DW'(unsigned'(prod));
					state_q <= S_PDY;
				end
				S_PDY: begin
					dist_q <= dist_q + DW'(unsigned'(prod));
					state_q <= S_PGAP;
				end
				S_PGAP: begin
					gap2_q <= prod[31:0];
					state_q <= S_PX;
				end
				S_PX: begin
					len_q <= prod[LW-1:0];
					state_q <= S_PY;
				end
				S_PY: begin
					len_q <= len_q + prod[LW-1:0];
					state_q <= S_DECIDE;
				end
				S_DECIDE: begin
					if (!open_q) begin
						open_q <= 1'b1;
						hx_q <= x_q; tx_q <= x_q; nx_q <= x_q;
						hy_q <= y_q; ty_q <= y_q; ny_q <= y_q;
						head_len_q <= len_q; tail_len_q <= len_q; near_len_q <= len_q;
						state_q <= S_ENDCHK;
					end else if (extend) begin
						tx_q <= x_q;
						ty_q <= y_q;
						tail_len_q <= len_q;
						if (len_q < near_len_q) begin
							nx_q <= x_q;
							ny_q <= y_q;
							near_len_q <= len_q;
						end
						state_q <= S_ENDCHK;
					end else begin
						brk_q <= 1'b1;
						state_q <= S_DOT1;
					end
				end
				S_ENDCHK: begin
					if (!end_q) begin
						state_q <= S_IDLE;
					end else if (open_q) begin
						brk_q <= 1'b0;
						state_q <= S_DOT1;
					end else if (out_free) begin
						seg_q <= 1'b0;
						done_q <= 1'b1;
						osx_q <= '0; osy_q <= '0; oex_q <= '0;
						oey_q <= '0; onx_q <= '0; ony_q <= '0;
						state_q <= S_IDLE;
					end
				end
				S_DOT1: begin
					dot_q <= DTW'(prod);
					state_q <= S_DOT2;
				end
				S_DOT2: begin
					dot_q <= dot_q + DTW'(prod);
					state_q <= S_CSQ;
				end
				S_CSQ: begin
					c2_q <= unsigned'(prod[COS_SQ_W-1:0]);
					state_q <= S_TEST;
				end
				S_TEST: begin
					if (head_len_q == '0 || tail_len_q == '0) begin
						ok_q <= 1'b0;
						state_q <= S_RESULT;
					end else if (!c_neg && dot_le0) begin
						ok_q <= 1'b1;
						state_q <= S_RESULT;
					end else if (c_neg && dot_ge0) begin
						ok_q <= 1'b0;
						state_q <= S_RESULT;
					end else begin
						state_q <= S_M1;
					end
				end
				S_M1: state_q <= S_M1W;
				S_M1W: if (ser_done) state_q <= S_M2;
				S_M2: state_q <= S_M2W;
				S_M2W: begin
					if (ser_done) begin
						r_q <= ser_prod;
						state_q <= S_M3;
					end
				end
				S_M3: state_q <= S_M3W;
				S_M3W: if (ser_done) state_q <= S_CMP;
				S_CMP: begin
					ok_q <= c_neg ? (lhs >= r_q) : (lhs <= r_q);
					state_q <= S_RESULT;
				end
				S_RESULT: begin
					if (out_free || (brk_q && !ok_q)) begin
						if (ok_q || !brk_q) begin
							seg_q <= ok_q;
							done_q <= !brk_q;
							osx_q <= ok_q ? hx_q : '0;
							osy_q <= ok_q ? hy_q : '0;
							oex_q <= ok_q ? tx_q : '0;
							oey_q <= ok_q ? ty_q : '0;
							onx_q <= ok_q ? nx_q : '0;
							ony_q <= ok_q ? ny_q : '0;
						end
						if (brk_q) begin
							hx_q <= x_q; tx_q <= x_q; nx_q <= x_q;
							hy_q <= y_q; ty_q <= y_q; ny_q <= y_q;
							head_len_q <= len_q; tail_len_q <= len_q; near_len_q <= len_q;
							state_q <= S_ENDCHK;
						end else begin
							open_q <= 1'b0;
							state_q <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser = seg_q;
	assign m_tlast = done_q;
	assign m_tdata = M_TDATA_W'({ony_q, onx_q, oey_q, oex_q, osy_q, osx_q});

endmodule

### rtl/lsbs_checker.sv
module lsbs_checker #(
	parameter int COORD_BITS = 16,
	localparam int S_TDATA_W = ((2*COORD_BITS + 7) / 8) * 8,
	localparam int M_TDATA_W = ((6*COORD_BITS + 7) / 8) * 8
) (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           cfg_valid,
	input logic                           cfg_ready,
	input logic [lsbs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input logic [lsbs_pkg::CFG_DATA_W-1:0] cfg_data,
	input logic                           s_tvalid,
	input logic                           s_tready,
	input logic [S_TDATA_W-1:0]           s_tdata,
	input logic                           s_tlast,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [M_TDATA_W-1:0]           m_tdata,
	input logic                           m_tuser,
	input logic                           m_tlast
);

	// a stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast))
		else $error("result beat changed while stalled");

	// an empty result only closes a scan and carries zeros
	a_empty_result: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tlast && (m_tdata == '0))
		else $error("empty result not a zeroed scan end");

	// one point at a time: busy right after a beat is taken
	a_busy_after_in: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken on back-to-back cycles");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("config write stalled");

endmodule

bind lidar_scan_breakpoint_segmenter lsbs_checker #(.COORD_BITS(COORD_BITS)) u_lsbs_checker (.*);

### test/lidar_scan_breakpoint_segmenter_tb.sv
module lidar_scan_breakpoint_segmenter_tb;
	import lsbs_pkg::*;

	localparam int CB = 16;
	localparam int LIMIT = 3000000;
	// index past the register list, must be ignored
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 8'd9;

	typedef struct packed {
		logic seg;
		logic signed [CB-1:0] sx, sy, ex, ey, nx, ny;
		logic done;
	} seg_t;

	typedef struct {
		logic signed [CB-1:0] x, y;
		logic last;
		logic chk;
		seg_t res0;
		int nres;
	} row_t;

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic s_tvalid = 0;
	logic s_tready;
	logic [2*CB-1:0] s_tdata = '0;
	logic s_tlast = 0;
	logic m_tvalid;
	logic m_tready = 0;
	logic [6*CB-1:0] m_tdata;
	logic m_tuser;
	logic m_tlast;

	lidar_scan_breakpoint_segmenter #(.COORD_BITS(CB)) u_dut (.*);

	always #1 clk = ~clk;

	// predictor state
	logic signed [15:0] gate_lo, gate_hi, span_cos;
	logic [15:0] gap;
	bit in_cluster;
	logic signed [CB-1:0] hx, hy, tx, ty, nrx, nry;
	logic [63:0] near_d;

	seg_t seg_q[$];
	int errors = 0;
	int cycles = 0;
	int send_idle = 0, recv_stall = 0;
	bit hold_off = 0;

	function automatic logic [63:0] len_sq(longint x, longint y);
		return x * x + y * y;
	endfunction

	function automatic bit span_pass();
		logic [63:0] f, l;
		longint dot, c;
		logic [255:0] lhs, rhs;
		f = len_sq(hx, hy);
		l = len_sq(tx, ty);
		if (f == 0 || l == 0) return 0;
		dot = longint'(hx) * tx + longint'(hy) * ty;
		c = span_cos;
		if (c >= 0 && dot <= 0) return 1;
		if (c < 0 && dot >= 0) return 0;
		if (dot < 0) dot = -dot;
		lhs = 256'(dot) * 32768 * 256'(dot) * 32768;
		rhs = 256'(f) * 256'(l) * 256'(c * c);
		return (c >= 0) ? (lhs <= rhs) : (lhs >= rhs);
	endfunction

	function automatic seg_t make_seg(bit ok, bit done);
		seg_t s;
		s = '0;
		s.seg = ok;
		s.done = done;
		if (ok) begin
			s.sx = hx; s.sy = hy; s.ex = tx; s.ey = ty; s.nx = nrx; s.ny = nry;
		end
		return s;
	endfunction

	function automatic void seed_cluster(logic signed [CB-1:0] x, logic signed [CB-1:0] y);
		in_cluster = 1;
		hx = x; hy = y; tx = x; ty = y; nrx = x; nry = y;
		near_d = len_sq(x, y);
	endfunction

	function automatic void segment_point(logic signed [CB-1:0] x, logic signed [CB-1:0] y,
			logic last);
		logic [63:0] d;
		bit ok;
		if (x > gate_lo && x < gate_hi && y > gate_lo && y < gate_hi) begin
			if (!in_cluster) seed_cluster(x, y);
			else if (len_sq(longint'(x) - tx, longint'(y) - ty) <= 64'(gap) * gap) begin
				d = len_sq(x, y);
				tx = x; ty = y;
				if (d < near_d) begin
					nrx = x; nry = y; near_d = d;
				end
			end else begin
				if (span_pass()) seg_q = {seg_q, make_seg(1, 0)};
				seed_cluster(x, y);
			end
		end
		if (last) begin
			ok = in_cluster && span_pass();
			seg_q = {seg_q, make_seg(ok, 1)};
			in_cluster = 0;
		end
	endfunction

	// receiver
	always @(posedge clk) begin
		seg_t got, want;
		cycles <= cycles + 1;
		if (m_tvalid && m_tready) begin
			got = {m_tuser, m_tdata[95:80], m_tdata[79:64], m_tdata[63:48], m_tdata[47:32],
				m_tdata[31:16], m_tdata[15:0], m_tlast};
			got.sx = m_tdata[15:0]; got.sy = m_tdata[31:16];
			got.ex = m_tdata[47:32]; got.ey = m_tdata[63:48];
			got.nx = m_tdata[79:64]; got.ny = m_tdata[95:80];
			if (seg_q.size() == 0) begin
				$display("%0t: expected none actual %h", $time, got);
				errors++;
			end else begin
				want = seg_q.pop_front();
				if (got !== want) begin
					$display("%0t: expected %h actual %h", $time, want, got);
					errors++;
				end
			end
		end
		if (cycles > LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	always @(negedge clk)
		m_tready <= !hold_off && ($urandom_range(99) >= recv_stall);

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
		@(negedge clk);
		cfg_valid <= 1; cfg_index <= idx; cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			REG_GATE_LOW: gate_lo = val;
			REG_GATE_HIGH: gate_hi = val;
			REG_BREAK_GAP: gap = val;
			REG_SPAN_COS: span_cos = val;
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 0;
	endtask

	task automatic send_point(logic signed [CB-1:0] x, logic signed [CB-1:0] y, logic last);
		@(negedge clk);
		while ($urandom_range(99) < send_idle) @(negedge clk);
		s_tvalid <= 1; s_tdata <= {y, x}; s_tlast <= last;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		segment_point(x, y, last);
		@(negedge clk);
		s_tvalid <= 0;
	endtask

	task automatic drain();
		while (seg_q.size() != 0) @(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	function automatic logic signed [CB-1:0] rnd_coord(int span);
		if ($urandom_range(9) == 0) return CB'($urandom);
		return CB'($signed($urandom_range(2 * span)) - span);
	endfunction

	task automatic random_scans(int n);
		logic signed [CB-1:0] x, y;
		int k;
		x = 3000; y = 0;
		for (k = 0; k < n; k++) begin
			if ($urandom_range(7) == 0) begin
				x = rnd_coord(12000); y = rnd_coord(12000);
			end else begin
				x = x + CB'($signed($urandom_range(500)) - 250);
				y = y + CB'($signed($urandom_range(500)) - 250);
			end
			send_point(x, y, $urandom_range(39) == 0 || k == n - 1);
		end
	endtask

	row_t dir[$];
	row_t r;
	seg_t z;

	initial begin
		int ph;
		gate_lo = RST_GATE_LOW; gate_hi = RST_GATE_HIGH;
		gap = RST_BREAK_GAP; span_cos = RST_SPAN_COS;
		in_cluster = 0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1;

		// directed table; chk rows carry their typed result in res0
		z = '0; z.done = 1;
		r = '{x: 0, y: 0, last: 1, chk: 1, res0: z, nres: 1}; dir = {dir, r};
		r = '{x: 16'sh7fff, y: 16'sh8000, last: 1, chk: 1, res0: z, nres: 1}; dir = {dir, r};
		r = '{x: -10000, y: 0, last: 1, chk: 1, res0: z, nres: 1}; dir = {dir, r};
		r = '{x: 0, y: 0, last: 0, chk: 0, res0: z, nres: 0}; dir = {dir, r};
		r = '{x: 100, y: 0, last: 0, chk: 0, res0: z, nres: 0}; dir = {dir, r};
		r = '{x: 5000, y: 0, last: 0, chk: 0, res0: z, nres: 0}; dir = {dir, r};
		r = '{x: 5000, y: 200, last: 0, chk: 0, res0: z, nres: 0}; dir = {dir, r};
		r = '{x: 5000, y: 400, last: 0, chk: 0, res0: z, nres: 0}; dir = {dir, r};
		r = '{x: 4990, y: 600, last: 0, chk: 0, res0: z, nres: 0}; dir = {dir, r};
		r = '{x: -3000, y: 9999, last: 0, chk: 0, res0: z, nres: 0}; dir = {dir, r};
		r = '{x: -3000, y: 9800, last: 0, chk: 0, res0: z, nres: 0}; dir = {dir, r};
		r = '{x: 9999, y: -9999, last: 1, chk: 0, res0: z, nres: 0}; dir = {dir, r};
		r = '{x: 2000, y: 2000, last: 0, chk: 0, res0: z, nres: 0}; dir = {dir, r};
		r = '{x: 2000, y: 2300, last: 0, chk: 0, res0: z, nres: 0}; dir = {dir, r};
		r = '{x: 2000, y: 2600, last: 0, chk: 0, res0: z, nres: 0}; dir = {dir, r};
		r = '{x: 20000, y: 0, last: 1, chk: 0, res0: z, nres: 0}; dir = {dir, r};
		foreach (dir[i]) begin
			send_point(dir[i].x, dir[i].y, dir[i].last);
			if (dir[i].chk) begin
				// the result cannot leave the block this soon, so it is still queued
				if (seg_q.size() != dir[i].nres ||
						(dir[i].nres > 0 && seg_q[0] !== dir[i].res0)) begin
					$display("%0t: expected %0d x %h actual %0d x %h", $time, dir[i].nres,
						dir[i].res0, seg_q.size(), (seg_q.size() > 0) ? seg_q[0] : '0);
					errors++;
				end
				drain();
			end
		end
		drain();

		for (ph = 0; ph < 6; ph++) begin
			case (ph)
				0: begin send_idle = 0; recv_stall = 0; end
				1: begin send_idle = 73; recv_stall = 0; end
				2: begin send_idle = 0; recv_stall = 73; end
				3: begin send_idle = 6; recv_stall = 6; end
				4: begin send_idle = 0; recv_stall = 0; end
				default: begin send_idle = 6; recv_stall = 73; end
			endcase
			case (ph)
				1: begin write_reg(REG_BREAK_GAP, 16'hffff); write_reg(REG_SPAN_COS, 16'h8000); end
				2: begin write_reg(REG_GATE_LOW, 16'h8000); write_reg(REG_GATE_HIGH, 16'h7fff);
					write_reg(REG_BREAK_GAP, 16'd0); write_reg(REG_SPAN_COS, 16'h7fff); end
				3: begin write_reg(REG_GATE_LOW, -16'sd2000); write_reg(REG_GATE_HIGH, 16'sd9000);
					write_reg(REG_BREAK_GAP, 16'd250); write_reg(REG_SPAN_COS, 16'd0); end
				4: begin write_reg(REG_UNUSED, 16'h1234); write_reg(REG_SPAN_COS, -16'sd16000);
					write_reg(REG_BREAK_GAP, 16'd400); end
				5: begin write_reg(REG_GATE_LOW, RST_GATE_LOW);
					write_reg(REG_GATE_HIGH, RST_GATE_HIGH);
					write_reg(REG_BREAK_GAP, RST_BREAK_GAP);
					write_reg(REG_SPAN_COS, 16'sd31000); end
				default: ;
			endcase
			if (ph == 0) begin
				// long receiver hold-off while the sender keeps pushing
				hold_off = 1;
				fork
					random_scans(40);
					begin repeat (3000) @(posedge clk); hold_off = 0; end
				join
			end
			random_scans(300);
			drain();
		end
		if (errors == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end
endmodule

### filelist.f
rtl/lsbs_pkg.sv
rtl/lsbs_mul.sv
rtl/lidar_scan_breakpoint_segmenter.sv
rtl/lsbs_checker.sv
test/lidar_scan_breakpoint_segmenter_tb.sv
